>>> design/aes_pkg.sv
// Package with AES constants, types and round functions shared by the cipher design.
package aes_pkg;

	localparam int unsigned NUM_ROUNDS = 14;
	localparam int unsigned RK_IDX_W = 4;
	localparam int unsigned ADDR_W = 6;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	// Register byte addresses (8-byte spacing).
	localparam logic [ADDR_W-1:0] ADDR_KEY0 = 6'd0;
	localparam logic [ADDR_W-1:0] ADDR_KEY1 = 6'd8;
	localparam logic [ADDR_W-1:0] ADDR_KEY2 = 6'd16;
	localparam logic [ADDR_W-1:0] ADDR_KEY3 = 6'd24;
	localparam logic [ADDR_W-1:0] ADDR_IVH = 6'd32;
	localparam logic [ADDR_W-1:0] ADDR_IVL = 6'd40;
	localparam logic [ADDR_W-1:0] ADDR_MODE = 6'd48;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Byte n of a block is bits [127-8n -: 8].
	function automatic byte_t get_byte(input block_t b, input int unsigned n);
		get_byte = b[127-8*n -: 8];
	endfunction

	function automatic byte_t xt(input byte_t a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t sub_bytes(input block_t s);
		block_t t;
		for (int i = 0; i < 16; i++) t[127-8*i -: 8] = SBOX[get_byte(s, i)];
		sub_bytes = t;
	endfunction

	function automatic block_t inv_sub_bytes(input block_t s);
		block_t t;
		for (int i = 0; i < 16; i++) t[127-8*i -: 8] = INV_SBOX[get_byte(s, i)];
		inv_sub_bytes = t;
	endfunction

	function automatic block_t shift_rows(input block_t s);
		block_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c+r)%4));
		shift_rows = t;
	endfunction

	function automatic block_t inv_shift_rows(input block_t s);
		block_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r + 4*c);
		inv_shift_rows = t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c); a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
			t[127-8*(4*c) -: 8]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			t[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			t[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		mix_columns = t;
	endfunction

	// Inverse mix: premultiply each column by {05,00,04,00} pattern, then forward mix.
	function automatic block_t inv_mix_columns(input block_t s);
		block_t t;
		byte_t u, v;
		t = s;
		for (int c = 0; c < 4; c++) begin
			u = xt(xt(get_byte(s, 4*c) ^ get_byte(s, 4*c+2)));
			v = xt(xt(get_byte(s, 4*c+1) ^ get_byte(s, 4*c+3)));
			t[127-8*(4*c) -: 8]   = get_byte(s, 4*c) ^ u;
			t[127-8*(4*c+1) -: 8] = get_byte(s, 4*c+1) ^ v;
			t[127-8*(4*c+2) -: 8] = get_byte(s, 4*c+2) ^ u;
			t[127-8*(4*c+3) -: 8] = get_byte(s, 4*c+3) ^ v;
		end
		inv_mix_columns = mix_columns(t);
	endfunction

endpackage

>>> design/aes_stream_if.sv
// Valid/ready stream interfaces for the cipher's input and result channels.
interface aes_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        first_block;
	modport source (output valid, block_high, block_low, first_block, input ready);
	modport sink (input valid, block_high, block_low, first_block, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

>>> design/aes256_cbc_cipher.sv
// AES-256 CBC cipher: one round unit, key expansion sequencer and APB registers.
// Blocks are processed one at a time: a new input is accepted only in idle, once the
// previous block has left the round unit. Key expansion runs first on the first block
// after reset or after any key write.
// A finished block waits in its last round while the output register is still full.
// Reset (arst_n low) clears control state, registers, chaining value and keys-valid flag.
module aes256_cbc_cipher (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [aes_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	aes_in_if.sink                     in_ch,
	aes_out_if.source                  out_ch
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYEXP,
		ST_ROUND
	} state_t;

	state_t state_q;

	logic [63:0] key0_q, key1_q, key2_q, key3_q, ivh_q, ivl_q;
	logic        decrypt_q;
	logic        keys_ready_q;
	aes_pkg::block_t chain_q, state_blk_q, cipher_in_q;
	logic        first_q;

	// Key expansion runs on a 256-bit window holding the last eight words.
	// Each step produces two round keys' worth of words (eight words).
	logic [255:0] kwin_q;
	logic [7:0]   rcon_q;
	logic [aes_pkg::RK_IDX_W-1:0] round_q;

	// Round key memory: 15 entries, written during expansion, read once a cycle except while the last round stalls.
	aes_pkg::block_t rk_mem [15];
	aes_pkg::block_t rk_rd_q;
	logic [aes_pkg::RK_IDX_W-1:0] rk_rd_addr;
	logic [aes_pkg::RK_IDX_W-1:0] rk_wr_addr;
	aes_pkg::block_t rk_wr_data;
	logic            rk_wr_en;

	logic out_valid_q;
	logic [63:0] out_hi_q, out_lo_q;

	// The last round holds while the previous result still waits in the output
	// register; res_load marks the cycle in which the new result is loaded.
	logic out_stall;
	logic res_load;
	assign out_stall = (state_q == ST_ROUND) && (round_q == 4'd15) && out_valid_q
		&& !out_ch.ready;
	assign res_load = (state_q == ST_ROUND) && (round_q == 4'd15) && !out_stall;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr)
			aes_pkg::ADDR_KEY0: prdata = key0_q;
			aes_pkg::ADDR_KEY1: prdata = key1_q;
			aes_pkg::ADDR_KEY2: prdata = key2_q;
			aes_pkg::ADDR_KEY3: prdata = key3_q;
			aes_pkg::ADDR_IVH:  prdata = ivh_q;
			aes_pkg::ADDR_IVL:  prdata = ivl_q;
			aes_pkg::ADDR_MODE: prdata = {63'd0, decrypt_q};
			default:            prdata = 64'd0;
		endcase
	end

	// One key expansion step: next eight words from the previous eight.
	logic [255:0] kwin_next;
	always_comb begin
		logic [31:0] w [8];
		logic [31:0] t;
		for (int i = 0; i < 8; i++) w[i] = kwin_q[255-32*i -: 32];
		t = w[7];
		t = {aes_pkg::SBOX[t[23:16]] ^ rcon_q, aes_pkg::SBOX[t[15:8]],
			aes_pkg::SBOX[t[7:0]], aes_pkg::SBOX[t[31:24]]};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		t = {aes_pkg::SBOX[w[3][31:24]], aes_pkg::SBOX[w[3][23:16]],
			aes_pkg::SBOX[w[3][15:8]], aes_pkg::SBOX[w[3][7:0]]};
		w[4] = w[4] ^ t;
		w[5] = w[5] ^ w[4];
		w[6] = w[6] ^ w[5];
		w[7] = w[7] ^ w[6];
		for (int i = 0; i < 8; i++) kwin_next[255-32*i -: 32] = w[i];
	end

	// The expansion writes one key per cycle: kidx 0 writes key 0 (the first
	// half of the window), odd/even cycles alternate halves of the window.
	logic [3:0] kidx_q;
	always_comb begin
		rk_wr_en   = (state_q == ST_KEYEXP);
		rk_wr_addr = kidx_q;
		rk_wr_data = kidx_q[0] ? kwin_q[127:0] : kwin_q[255:128];
	end

	// Round counter selects the key: forward counts up, inverse counts down.
	assign rk_rd_addr = decrypt_q ? aes_pkg::RK_IDX_W'(4'd14 - round_q) : round_q;

	always_ff @(posedge clk) begin
		if (rk_wr_en) rk_mem[rk_wr_addr] <= rk_wr_data;
		if (!out_stall) rk_rd_q <= rk_mem[rk_rd_addr];
	end

	// Shared round unit.
	aes_pkg::block_t round_out;
	always_comb begin
		aes_pkg::block_t x;
		if (!decrypt_q) begin
			x = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_blk_q));
			if (round_q != 4'd15) x = aes_pkg::mix_columns(x);
			round_out = x ^ rk_rd_q;
		end else begin
			x = aes_pkg::inv_sub_bytes(aes_pkg::inv_shift_rows(state_blk_q)) ^ rk_rd_q;
			round_out = (round_q != 4'd15) ? aes_pkg::inv_mix_columns(x) : x;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.result_high = out_hi_q;
	assign out_ch.result_low = out_lo_q;
	logic in_xfer;
	assign in_xfer = in_ch.valid && in_ch.ready;

	// round_q: 0 issues the read of key 0 (or 14), 1 adds it, 2..15 apply
	// rounds 1..14 using the key read at the previous count.
	aes_pkg::block_t chain_sel;
	assign chain_sel = first_q ? {ivh_q, ivl_q} : chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			ivh_q <= '0; ivl_q <= '0; decrypt_q <= 1'b0;
			keys_ready_q <= 1'b0;
			chain_q <= '0;
			out_valid_q <= 1'b0;
			out_hi_q <= '0;
			out_lo_q <= '0;
			round_q <= '0;
			kidx_q <= '0;
			kwin_q <= '0;
			rcon_q <= 8'h01;
			first_q <= 1'b0;
			cipher_in_q <= '0;
			state_blk_q <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr)
					aes_pkg::ADDR_KEY0: begin key0_q <= pwdata; keys_ready_q <= 1'b0; end
					aes_pkg::ADDR_KEY1: begin key1_q <= pwdata; keys_ready_q <= 1'b0; end
					aes_pkg::ADDR_KEY2: begin key2_q <= pwdata; keys_ready_q <= 1'b0; end
					aes_pkg::ADDR_KEY3: begin key3_q <= pwdata; keys_ready_q <= 1'b0; end
					aes_pkg::ADDR_IVH:  ivh_q <= pwdata;
					aes_pkg::ADDR_IVL:  ivl_q <= pwdata;
					aes_pkg::ADDR_MODE: decrypt_q <= pwdata[0];
					default: ;
				endcase
			end
			if (res_load) out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					round_q <= '0;
					if (in_xfer) begin
						cipher_in_q <= {in_ch.block_high, in_ch.block_low};
						first_q <= in_ch.first_block;
						if (keys_ready_q) state_q <= ST_ROUND;
						else begin
							state_q <= ST_KEYEXP;
							kwin_q <= {key0_q, key1_q, key2_q, key3_q};
							kidx_q <= '0;
							rcon_q <= 8'h01;
						end
					end
				end
				ST_KEYEXP: begin
					kidx_q <= kidx_q + 4'd1;
					if (kidx_q[0]) begin
						kwin_q <= kwin_next;
						rcon_q <= aes_pkg::xt(rcon_q);
					end
					if (kidx_q == 4'd14) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (!out_stall) begin
						round_q <= round_q + 4'd1;
						if (round_q == 4'd0) begin
							state_blk_q <= decrypt_q ? cipher_in_q : cipher_in_q ^ chain_sel;
							if (first_q) chain_q <= {ivh_q, ivl_q};
						end else if (round_q == 4'd1) begin
							state_blk_q <= state_blk_q ^ rk_rd_q;
						end else begin
							state_blk_q <= round_out;
						end
						if (round_q == 4'd15) begin
							state_q <= ST_IDLE;
							if (decrypt_q) begin
								{out_hi_q, out_lo_q} <= round_out ^ chain_q;
								chain_q <= cipher_in_q;
							end else begin
								{out_hi_q, out_lo_q} <= round_out;
								chain_q <= round_out;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// round_q counts 0..15; the round applied at round_q = r+1 is round r.
	// Keys read at round_q give the key for the next cycle, so the read
	// address is offset by one through the registered read above; the read
	// at count r returns key r (key 14 - r when decrypting) at count r+1, used in round r for r >= 1.

endmodule

>>> dv/aes256_cbc_cipher_tb.sv
// Self-checking testbench for the AES-256 CBC cipher: predicted results checked in order.
module aes256_cbc_cipher_tb;

	typedef logic [7:0] tb_byte_t;
	typedef logic [127:0] blk_t;

	// The expected ciphertext or plaintext of every accepted input transfer, oldest first.
	class cbc_scoreboard;
		blk_t pending_results[$];
		int   n_checked;

		function void note_input(blk_t r);
			pending_results.push_back(r);
		endfunction

		function int check_result(blk_t got, output blk_t want);
			if (pending_results.size() == 0) return 2;
			want = pending_results.pop_front();
			n_checked++;
			return (got === want) ? 0 : 1;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [aes_pkg::ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	aes_in_if in_ch ();
	aes_out_if out_ch ();

	aes256_cbc_cipher dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	always #4 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.block_high = '0;
		in_ch.block_low = '0;
		in_ch.first_block = 1'b0;
		out_ch.ready = 1'b0;
	end

	cbc_scoreboard sb = new();
	int n_errors;
	int n_sent;
	int n_dec_sent;
	bit idle_allowed = 1'b1;
	int hold_off_cycles;

	// Predictor copy of the registers and the chaining state.
	logic [63:0] key_reg [4];
	logic [63:0] iv_hi_reg, iv_lo_reg;
	logic        decrypting;
	blk_t        chain;
	blk_t        rk [15];

	// Bytes of a block are numbered from the most significant end, as in the port fields.
	function automatic tb_byte_t bget(blk_t b, int n);
		return b[127-8*n -: 8];
	endfunction

	function automatic tb_byte_t dbl(tb_byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic tb_byte_t gf_mul(tb_byte_t a, tb_byte_t b);
		tb_byte_t p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p ^= a;
			a = dbl(a);
			b = b >> 1;
		end
		return p;
	endfunction

	// The substitution table is derived here from the field inverse and the affine map,
	// rather than taken from the package, so the two are independent.
	tb_byte_t fwd_sub [256];
	tb_byte_t rev_sub [256];

	task automatic build_sub_tables();
		tb_byte_t inv, s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			for (int i = 0; i < 254; i++) inv = gf_mul(inv, x[7:0]);
			if (x == 0) inv = 8'h00;
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_sub[x] = s;
			rev_sub[s] = x[7:0];
		end
	endtask

	// Standard AES-256 key schedule: 60 words, 15 round keys.
	task automatic expand_round_keys();
		logic [31:0] w [60];
		logic [31:0] t;
		tb_byte_t rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) begin
			w[2*i] = key_reg[i][63:32];
			w[2*i+1] = key_reg[i][31:0];
		end
		for (int i = 8; i < 60; i++) begin
			t = w[i-1];
			if (i % 8 == 0) begin
				t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]], fwd_sub[t[31:24]]};
				rc = dbl(rc);
			end else if (i % 8 == 4) begin
				t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
			end
			w[i] = w[i-8] ^ t;
		end
		for (int r = 0; r < 15; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endtask

	function automatic blk_t subst(blk_t s, bit inverse);
		blk_t t;
		for (int i = 0; i < 16; i++)
			t[127-8*i -: 8] = inverse ? rev_sub[bget(s, i)] : fwd_sub[bget(s, i)];
		return t;
	endfunction

	function automatic blk_t rows(blk_t s, bit inverse);
		blk_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (inverse) t[127-8*(r+4*((c+r)%4)) -: 8] = bget(s, r + 4*c);
				else t[127-8*(r+4*c) -: 8] = bget(s, r + 4*((c+r)%4));
		return t;
	endfunction

	function automatic blk_t columns(blk_t s, bit inverse);
		tb_byte_t m [4];
		tb_byte_t acc;
		blk_t t;
		m = inverse ? '{8'd14, 8'd11, 8'd13, 8'd9} : '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++) acc ^= gf_mul(m[(k - r + 4) % 4], bget(s, 4*c + k));
				t[127-8*(4*c+r) -: 8] = acc;
			end
		return t;
	endfunction

	function automatic blk_t encrypt_block(blk_t s);
		s ^= rk[0];
		for (int r = 1; r <= 14; r++) begin
			s = rows(subst(s, 1'b0), 1'b0);
			if (r != 14) s = columns(s, 1'b0);
			s ^= rk[r];
		end
		return s;
	endfunction

	function automatic blk_t decrypt_block(blk_t s);
		s ^= rk[14];
		for (int r = 13; r >= 0; r--) begin
			s = subst(rows(s, 1'b1), 1'b1) ^ rk[r];
			if (r != 0) s = columns(s, 1'b1);
		end
		return s;
	endfunction

	// Works out the result of one accepted block and advances the chaining value.
	function automatic blk_t predict_cbc(blk_t blk, bit first);
		blk_t res;
		if (first) chain = {iv_hi_reg, iv_lo_reg};
		if (decrypting) begin
			res = decrypt_block(blk) ^ chain;
			chain = blk;
		end else begin
			res = encrypt_block(blk ^ chain);
			chain = res;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, blk_t got, blk_t want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		n_errors++;
	endtask

	// Two-phase register write; pready is tied high so the access phase completes at once.
	// Index 7 lies beyond the register map and must leave everything unchanged.
	task automatic reg_write(int idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= aes_pkg::ADDR_W'(8 * idx); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			0, 1, 2, 3: begin
				key_reg[idx] = value;
				expand_round_keys();
			end
			4: iv_hi_reg = value;
			5: iv_lo_reg = value;
			6: decrypting = value[0];
			default: ;
		endcase
	endtask

	task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit first);
		if (idle_allowed && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.block_high <= hi;
		in_ch.block_low <= lo;
		in_ch.first_block <= first;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(predict_cbc({hi, lo}, first));
		n_sent++;
		if (decrypting) n_dec_sent++;
	endtask

	task automatic end_burst();
		@(posedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Waits until every predicted result has arrived, then lets the pipeline settle.
	task automatic drain();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// The receiver stalls in random bursts, and once holds off for a long stretch so that
	// the block fills up and refuses further input transfers.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_off_cycles--;
			end else if (idle_allowed && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Result checker: each result transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		blk_t want;
		int verdict;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			verdict = sb.check_result({out_ch.result_high, out_ch.result_low}, want);
			if (verdict == 2) report_mismatch("unexpected result",
				{out_ch.result_high, out_ch.result_low}, 'x);
			else if (verdict == 1) report_mismatch("result",
				{out_ch.result_high, out_ch.result_low}, want);
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int len;
		build_sub_tables();
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		iv_hi_reg = '0; iv_lo_reg = '0; decrypting = 1'b0; chain = '0;
		expand_round_keys();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: a message with no first block chains from the reset value, then
		// extremes of the block under the all-zero key.
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b0);
		send_block('0, '0, 1'b1);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
		end_burst();
		drain();

		// The standard test key with an all-ones IV, then a mode change mid-message.
		reg_write(0, 64'h0001020304050607);
		reg_write(1, 64'h08090a0b0c0d0e0f);
		reg_write(2, 64'h1011121314151617);
		reg_write(3, 64'h18191a1b1c1d1e1f);
		reg_write(4, '1);
		reg_write(5, '1);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
		send_block('1, '0, 1'b0);
		end_burst();
		drain();
		reg_write(6, 64'hffff_fffe_0000_0001);
		send_block('0, '1, 1'b0);
		send_block(64'h8000000000000000, 64'h1, 1'b1);
		send_block(rand64(), rand64(), 1'b0);
		end_burst();
		drain();

		// A write out of range is ignored; the wide value keeps only its lowest bit.
		reg_write(7, '1);
		reg_write(6, 64'hffff_ffff_ffff_fffe);
		reg_write(0, '1); reg_write(1, '1); reg_write(2, '1); reg_write(3, '1);
		send_block('1, '1, 1'b1);
		send_block('0, '0, 1'b0);
		end_burst();
		drain();

		// Long receiver hold-off while the sender keeps offering blocks.
		hold_off_cycles = 200;
		for (int i = 0; i < 8; i++) send_block(rand64(), rand64(), i == 0);
		end_burst();
		drain();

		// Random phases: fresh settings, then messages of random length with random content.
		for (int phase = 0; phase < 16; phase++) begin
			if (phase == 13) idle_allowed = 1'b0;
			for (int i = 0; i < 4; i++)
				if ($urandom_range(0, 2) != 0) reg_write(i, rand64());
			reg_write(4, rand64());
			reg_write(5, rand64());
			reg_write(6, {$urandom(), $urandom()} & {63'h0, $urandom_range(0, 1) == 1});
			for (int k = 0; k < 125; k += len) begin
				len = $urandom_range(1, 12);
				for (int j = 0; j < len; j++)
					send_block(rand64(), rand64(), j == 0 && $urandom_range(0, 7) != 0);
			end
			end_burst();
			drain();
		end

		$display("Ran %0d blocks (%0d decrypted) over many key, IV and mode settings;",
			n_sent, n_dec_sent);
		$display("%0d results checked, %0d mismatches.", sb.n_checked, n_errors);
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

>>> aes256_cbc_cipher.f
design/aes_pkg.sv
design/aes_stream_if.sv
design/aes256_cbc_cipher.sv
dv/aes256_cbc_cipher_tb.sv
